/* rtl/tw_odo_pkg.sv */
// Shared types and constants for the tracking wheel odometry core.
package tw_odo_pkg;

	// CORDIC datapath width: wheel product (34b) times quarter turn, gain and margin
	localparam int CW = 37;
	// Rotated value after the 2^-12 rounding step
	localparam int MW = CW - 12;
	// Booth product of the rounded value and the inverse gain
	localparam int PW = MW + 32;

	localparam int CNT_W = 5;
	localparam int ATAN_N = 24;
	localparam int SR_W = 33;

	// Radix-4 digits: tiles_per_turn padded to 20 bits, inverse gain padded to 32 bits
	localparam int MUL_DIGITS = 10;
	localparam int SCL_DIGITS = 16;

	// Limit of the inverse CORDIC gain, Q30
	localparam logic [29:0] INV_GAIN_Q30 = 30'h26DD3B6A;

	// Configuration register indexes (paddr[2])
	localparam logic REG_TILES = 1'b0;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [31:0] ATAN_TURN32 [ATAN_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic               done;
		logic signed [31:0] gx;
		logic signed [31:0] gy;
	} rot_res_t;

endpackage

/* rtl/tw_odo_datapath.sv */
// Serial scaling, CORDIC rotation and gain correction of one two-wheel displacement vector.
module tw_odo_datapath #(
	parameter int CORDIC_STEPS = 16,
	parameter int ANGLE_BITS   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [15:0]    dx,
	input  logic signed [15:0]    dy,
	input  logic [17:0]           tiles,
	input  logic [15:0]           heading,
	output tw_odo_pkg::rot_res_t  res
);
	import tw_odo_pkg::*;

	localparam int AB = ANGLE_BITS;

	function automatic logic [ATAN_N*ANGLE_BITS-1:0] build_steps();
		logic [ATAN_N*ANGLE_BITS-1:0] r;
		logic [32:0]                  v;
		r = '0;
		for (int i = 0; i < ATAN_N; i++) begin
			v = {1'b0, ATAN_TURN32[i]} + (33'd1 << (31 - AB));
			r[i*AB +: AB] = AB'(v >> (32 - AB));
		end
		return r;
	endfunction

	localparam logic [ATAN_N*AB-1:0] STEPS = build_steps();
	localparam logic signed [AB-1:0] EIGHTH = AB'(1) << (AB - 3);

	// radix-4 Booth partial product
	function automatic logic signed [PW-1:0] booth_term(logic [2:0] b,
	                                                    logic signed [MW-1:0] m);
		logic signed [PW-1:0] e;
		logic signed [PW-1:0] t;
		e = PW'(m);
		case (b) inside
			3'b001, 3'b010: t = e;
			3'b011:         t = e <<< 1;
			3'b100:         t = -(e <<< 1);
			3'b101, 3'b110: t = -e;
			default:        t = '0;
		endcase
		return t;
	endfunction

	typedef enum logic [6:0] {
		P_IDLE = 7'b0000001,
		P_MUL  = 7'b0000010,
		P_PRE  = 7'b0000100,
		P_ROT  = 7'b0001000,
		P_RND  = 7'b0010000,
		P_SCL  = 7'b0100000,
		P_OUT  = 7'b1000000
	} phase_t;

	phase_t                  phase_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [SR_W-1:0]         sr_q;
	logic signed [MW-1:0]    mx_q, my_q;
	logic signed [PW-1:0]    ax_q, ay_q;
	logic signed [CW-1:0]    cx_q, cy_q;
	logic signed [AB-1:0]    z_q;
	logic [1:0]              quad_q;
	logic signed [31:0]      gx_q, gy_q;
	logic                    done_q;

	logic [39:0]             h_wide;
	logic [AB-1:0]           h_ang;
	logic [AB-1:0]           h_off;
	logic signed [AB-1:0]    z_init;
	logic signed [CW-1:0]    lx, ly, shx, shy, rx, ry;
	logic signed [AB-1:0]    step;
	logic signed [PW-1:0]    out_x, out_y;

	// heading to ANGLE_BITS, offset by an eighth turn, split into quadrant and residue
	assign h_wide = {heading, 24'd0};
	assign h_ang  = h_wide[39 -: AB];
	assign h_off  = h_ang + (AB'(1) << (AB - 3));
	assign z_init = $signed({2'b00, h_off[AB-3:0]}) - EIGHTH;

	assign lx    = ax_q[CW-1:0];
	assign ly    = ay_q[CW-1:0];
	assign shx   = cx_q >>> cnt_q;
	assign shy   = cy_q >>> cnt_q;
	assign step  = $signed(STEPS[cnt_q*AB +: AB]);
	assign rx    = cx_q + CW'(2048);
	assign ry    = cy_q + CW'(2048);
	assign out_x = ax_q + (PW'(1) <<< 33);
	assign out_y = ay_q + (PW'(1) <<< 33);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				P_IDLE: begin
					if (start) begin
						phase_q <= P_MUL;
						cnt_q   <= '0;
					end
				end
				P_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(MUL_DIGITS - 1))
						phase_q <= P_PRE;
				end
				P_PRE: begin
					phase_q <= P_ROT;
					cnt_q   <= '0;
				end
				P_ROT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(CORDIC_STEPS - 1))
						phase_q <= P_RND;
				end
				P_RND: begin
					phase_q <= P_SCL;
					cnt_q   <= '0;
				end
				P_SCL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SCL_DIGITS - 1))
						phase_q <= P_OUT;
				end
				P_OUT: begin
					phase_q <= P_IDLE;
					done_q  <= 1'b1;
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			P_IDLE: begin
				if (start) begin
					mx_q   <= MW'(dx);
					my_q   <= MW'(dy);
					ax_q   <= '0;
					ay_q   <= '0;
					sr_q   <= {2'b00, tiles, 1'b0, 12'd0};
					quad_q <= h_off[AB-1 -: 2];
					z_q    <= z_init;
				end
			end
			P_MUL, P_SCL: begin
				ax_q <= (ax_q <<< 2) + booth_term(sr_q[SR_W-1 -: 3], mx_q);
				ay_q <= (ay_q <<< 2) + booth_term(sr_q[SR_W-1 -: 3], my_q);
				sr_q <= sr_q << 2;
			end
			P_PRE: begin
				case (quad_q)
					2'd1: begin cx_q <= -ly; cy_q <= lx;  end
					2'd2: begin cx_q <= -lx; cy_q <= -ly; end
					2'd3: begin cx_q <= ly;  cy_q <= -lx; end
					default: begin cx_q <= lx; cy_q <= ly; end
				endcase
			end
			P_ROT: begin
				if (!z_q[AB-1]) begin
					cx_q <= cx_q - shy;
					cy_q <= cy_q + shx;
					z_q  <= z_q - step;
				end else begin
					cx_q <= cx_q + shy;
					cy_q <= cy_q - shx;
					z_q  <= z_q + step;
				end
			end
			P_RND: begin
				mx_q <= rx[CW-1:12];
				my_q <= ry[CW-1:12];
				ax_q <= '0;
				ay_q <= '0;
				sr_q <= {2'b00, INV_GAIN_Q30, 1'b0};
			end
			P_OUT: begin
				gx_q <= 32'($signed(out_x[PW-1:34]));
				gy_q <= 32'($signed(out_y[PW-1:34]));
			end
			default: ;
		endcase
	end

	assign res.done = done_q;
	assign res.gx   = gx_q;
	assign res.gy   = gy_q;

endmodule

/* rtl/tracking_wheel_odometry_core.sv */
// Top level of the two tracking wheel odometry core: stream ports, APB register, position.
//
// Dead-reckoning position from a sideways and a forward tracking wheel and a
// heading sensor. Each input request carries both wheel shaft angles and the
// heading as binary angles (65536 units per turn). An update request takes each
// wheel's change since the previous request as a signed 16-bit difference
// (half a turn counts as -32768), scales it by tiles_per_turn (Q2.16), rotates
// the local vector counterclockwise by the heading and adds it into saturating
// Q16.16 position registers. A reset request (tuser = 1) clears the position and
// takes the current wheel angles as reference; its heading is ignored. Every
// request yields one result with the new position.
// The datapath is digit serial. An update request runs through 10 radix-4 Booth
// scaling digits, a quadrant pre-rotation step, CORDIC_STEPS CORDIC iterations,
// a rounding step and 16 digits of Booth gain correction; the datapath then
// registers its result and done, the core enters its finish state and the
// output register loads once it is free. A reset request goes straight to the
// finish state and loads its result from there. One request is in work at a
// time; the next is accepted in the cycle after the result enters the output
// register, even while that result still waits for m_tready.
// tiles_per_turn lives at byte address 0 and resets to 23591; write it only
// while the core is idle.
module tracking_wheel_odometry_core #(
	parameter int CORDIC_STEPS = 16,
	parameter int ANGLE_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // x_wheel_angle[15:0], y_wheel_angle[31:16], heading_angle[47:32]
	input  logic [0:0]  s_tuser,   // cmd[0]: 0 update, 1 reset position
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // pos_x[31:0], pos_y[63:32]
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tw_odo_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
	                                               logic signed [31:0] b);
		logic signed [32:0] s;
		logic signed [31:0] r;
		s = 33'(a) + 33'(b);
		if (s[32] != s[31])
			r = s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
		else
			r = s[31:0];
		return r;
	endfunction

	state_t             state_q;
	logic [17:0]        tiles_q;
	logic [15:0]        last_x_q, last_y_q;
	logic signed [31:0] acc_x_q, acc_y_q;
	logic               cmd_q;
	logic               m_tvalid_q;
	logic [63:0]        m_tdata_q;

	logic               accept;
	logic               start;
	logic               out_load;
	logic signed [15:0] dx, dy;
	logic signed [31:0] nx, ny;
	rot_res_t           res;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign start    = accept & ~s_tuser[0];
	assign out_load = (state_q == ST_FIN) & (~m_tvalid_q | m_tready);

	// wrapping difference: the 16-bit result read as signed is the half-turn wrap
	assign dx = $signed(s_tdata[15:0] - last_x_q);
	assign dy = $signed(s_tdata[31:16] - last_y_q);

	assign nx = cmd_q ? 32'sd0 : sat_add(acc_x_q, res.gx);
	assign ny = cmd_q ? 32'sd0 : sat_add(acc_y_q, res.gy);

	tw_odo_datapath #(
		.CORDIC_STEPS (CORDIC_STEPS),
		.ANGLE_BITS   (ANGLE_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.dx      (dx),
		.dy      (dy),
		.tiles   (tiles_q),
		.heading (s_tdata[47:32]),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tiles_q    <= 18'd23591;
			last_x_q   <= '0;
			last_y_q   <= '0;
			acc_x_q    <= '0;
			acc_y_q    <= '0;
			cmd_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_TILES)
				tiles_q <= pwdata[17:0];

			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_x_q <= s_tdata[15:0];
						last_y_q <= s_tdata[31:16];
						cmd_q    <= s_tuser[0];
						state_q  <= s_tuser[0] ? ST_FIN : ST_CALC;
					end
				end
				ST_CALC: begin
					if (res.done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						acc_x_q <= nx;
						acc_y_q <= ny;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load)
			m_tdata_q <= {ny, nx};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_TILES) ? {14'd0, tiles_q} : 32'd0;

endmodule

/* rtl/tw_odo_checker.sv */
// Port-level checks for the tracking wheel odometry core, bound to the top level.
module tw_odo_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);
	import tw_odo_pkg::*;

	// one request in work at a time
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in work");

	// reset request into an empty output yields a zero position via the finish state
	a_reset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[0] && !m_tvalid |=> ##1 (m_tvalid && m_tdata == 64'd0))
		else $error("reset request did not give zero position");

	// register write reads back
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[2] == REG_TILES |=>
		(paddr[2] != REG_TILES || prdata == {14'd0, $past(pwdata[17:0])}))
		else $error("tiles_per_turn readback mismatch");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind tracking_wheel_odometry_core tw_odo_checker u_tw_odo_checker (.*);
